[sv/oklab_to_srgb8_pixel_defines.svh]
// Assertion macros shared by the checker of the Oklab to sRGB8 pixel pipeline.
// No dependencies; included by the checker file.
`ifndef OKLAB_TO_SRGB8_PIXEL_DEFINES_SVH
`define OKLAB_TO_SRGB8_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define O2S_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("o2s check failed");

// Next-cycle implication, disabled while reset is asserted.
`define O2S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("o2s check failed");

`endif

[sv/o2s_pkg.sv]
// Package for the Oklab to sRGB8 pixel pipeline: pixel types, matrix constants,
// constant-divider constants and the sRGB encode table generator. No dependencies.
package o2s_pkg;

    typedef struct packed {
        logic signed [15:0] lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } oklab_pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } srgb_pixel_t;

    localparam int NUM_STAGES = 20;
    localparam int DIV1_W     = 51;
    localparam int DIV2_W     = 48;

    // 1e10 = 2^10 * DIV_D; every matrix rescale is a divide by DIV_D
    localparam longint DIV_D      = 64'sd9765625;
    localparam longint DIV_OFFSET = 64'sd67108864;
    localparam longint BIAS1      = 64'sd4882812 + DIV_OFFSET * DIV_D;
    localparam longint HALF_DEC   = 64'sd5000000000;
    localparam longint FULL_LIMIT = DIV_D * 64'sd16777216;
    localparam longint ROUND24    = 64'sd8388608;

    typedef logic signed [35:0] coef1_t;
    typedef logic signed [36:0] coef2_t;

    // first matrix, coefficients of a and b per row (L coefficient is one)
    localparam coef1_t COEF_A [3] = '{36'sd3963377774, -36'sd1055613458, -36'sd894841775};
    localparam coef1_t COEF_B [3] = '{36'sd2158037573, -36'sd638541728, -36'sd12914855480};

    // second matrix, scale 1e10
    localparam coef2_t COEF_M [3][3] = '{
        '{37'sd40767416621, -37'sd33077115913, 37'sd2309699292},
        '{-37'sd12684380046, 37'sd26097574011, -37'sd3413193965},
        '{-37'sd41960863, -37'sd7034186147, 37'sd17076147010}
    };

    // true when idx/steps reaches the decode threshold of code v
    function automatic logic enc_reached(input int unsigned idx, input int unsigned v,
                                         input int unsigned steps);
        logic [255:0] lhs;
        logic [255:0] rhs;
        longint unsigned lin_l;
        longint unsigned lin_r;
        lhs = 256'd1;
        rhs = 256'd1;
        lin_l = 64'(idx) * 64'd32946;
        lin_r = 64'd5 * 64'(steps) * (64'd2 * 64'(v) - 64'd1);
        if (v == 0)
            return 1'b1;
        if (v <= 10)
            return lin_l >= lin_r;
        for (int k = 0; k < 5; k++) begin
            lhs = lhs * 256'(idx);
            rhs = rhs * 256'(steps);
        end
        for (int k = 0; k < 12; k++) begin
            lhs = lhs * 256'd10761;
            rhs = rhs * (256'd40 * 256'(v) + 256'd541);
        end
        return lhs >= rhs;
    endfunction

    // encode table entry: largest code whose threshold is reached
    function automatic logic [7:0] enc_entry(input int unsigned steps, input int unsigned idx);
        logic [8:0] lo_v;
        logic [8:0] hi_v;
        logic [8:0] mid;
        lo_v = 9'd0;
        hi_v = 9'd255;
        for (int n = 0; n < 8; n++) begin
            mid = (lo_v + hi_v + 9'd1) >> 1;
            if (enc_reached(idx, 32'(mid), steps))
                lo_v = mid;
            else
                hi_v = mid - 9'd1;
        end
        return lo_v[7:0];
    endfunction

endpackage

[sv/oklab_to_srgb8_pixel.sv]
// Oklab (Q2.14) to 8-bit sRGB pixel converter, top level.
// Uses o2s_pkg and o2s_cdiv.
//
// Input channel oklab_valid / oklab_stall / oklab carries one Oklab pixel per
// transaction; output channel srgb_valid / srgb_stall / srgb carries the sRGB
// pixel. A transaction completes at a clock edge with valid high and stall low.
// The datapath is a 20-stage pipeline (first matrix, a three-stage
// constant divider, cube, split second-matrix multiply, a second three-stage
// divider, and table interpolation). One pixel is accepted every cycle that oklab_stall is low.
// Each stage holds its own valid bit and advances when the stage after it
// moves or when it is empty, so bubbles close up while the receiver stalls;
// oklab_stall rises only when every stage holds a pixel and srgb_stall is high.
// A stalled output pixel stays unchanged. Reset clears all valid bits; the
// pipeline is empty and ready right after reset. The encode table is a
// constant built at elaboration from ENCODE_STEPS.
module oklab_to_srgb8_pixel #(
    parameter int ENCODE_STEPS = 511
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   oklab_valid,
    output logic                   oklab_stall,
    input  o2s_pkg::oklab_pixel_t  oklab,
    output logic                   srgb_valid,
    input  logic                   srgb_stall,
    output o2s_pkg::srgb_pixel_t   srgb
);
    import o2s_pkg::*;

    localparam int IDX_W = $clog2(ENCODE_STEPS + 1);
    localparam int I_W   = 24 + IDX_W;
    localparam int N     = NUM_STAGES;

    // stage control
    logic [N:1] valid_reg, valid_next, valid_in, en;
    logic       all_full;

    always_comb
    begin
        valid_in = {valid_reg[N-1:1], oklab_valid};
        for (int k = 1; k <= N; k++)
        begin
            all_full = 1'b1;
            for (int j = k; j <= N; j++)
                all_full = all_full & valid_reg[j];
            en[k] = !all_full || !srgb_stall;
        end
        valid_next = (en & valid_in) | (~en & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign oklab_stall = !en[1];
    assign srgb_valid  = valid_reg[N];

    // encode table
    logic [7:0] enc_rom [0:ENCODE_STEPS];
    for (genvar gi = 0; gi <= ENCODE_STEPS; gi++)
    begin : g_rom
        assign enc_rom[gi] = enc_entry(ENCODE_STEPS, gi);
    end

    // payload registers
    logic signed [51:0]   s1_pa_reg [3], s1_pa_next [3];
    logic signed [51:0]   s1_pb_reg [3], s1_pb_next [3];
    logic signed [15:0]   s1_l_reg;
    logic [DIV1_W-1:0]    s2_div_reg [3], s2_div_next [3];
    logic signed [15:0]   s2_l_reg, s3_l_reg, s4_l_reg, s5_l_reg;
    logic [DIV1_W-24:0]   q1 [3];
    logic signed [27:0]   s6_lp_reg [3], s6_lp_next [3];
    logic [52:0]          s7_sq_reg [3], s7_sq_next [3];
    logic signed [27:0]   s7_lp_reg [3];
    logic signed [57:0]   s8_cube_reg [3], s8_cube_next [3];
    logic signed [31:0]   s9_x_reg [3], s9_x_next [3];
    logic signed [52:0]   s10_ph_reg [3][3], s10_ph_next [3][3];
    logic signed [53:0]   s10_pl_reg [3][3], s10_pl_next [3][3];
    logic signed [54:0]   s11_hs_reg [3], s11_hs_next [3];
    logic signed [55:0]   s11_ls_reg [3], s11_ls_next [3];
    logic signed [69:0]   s12_s_reg [3], s12_s_next [3];
    logic [DIV2_W-1:0]    s13_div_reg [3], s13_div_next [3];
    logic [2:0]           s13_zero_reg, s13_zero_next, s13_full_reg, s13_full_next;
    logic [2:0]           s14_zero_reg, s14_full_reg, s15_zero_reg, s15_full_reg;
    logic [2:0]           s16_zero_reg, s16_full_reg;
    logic [DIV2_W-24:0]   q2 [3];
    logic [I_W-1:0]       s17_i_reg [3], s17_i_next [3];
    logic [2:0]           s17_zero_reg, s17_full_reg;
    logic [7:0]           s18_y0_reg [3], s18_y0_next [3];
    logic [7:0]           s18_dy_reg [3], s18_dy_next [3];
    logic [23:0]          s18_r_reg [3], s18_r_next [3];
    logic [2:0]           s18_zero_reg, s18_full_reg;
    logic [31:0]          s19_prod_reg [3], s19_prod_next [3];
    logic [7:0]           s19_y0_reg [3];
    logic [2:0]           s19_zero_reg, s19_full_reg;
    srgb_pixel_t          out_reg, out_next;

    // scratch
    logic [29:0]          lp_sum [3];
    logic [53:0]          sq_rnd [3];
    logic signed [57:0]   cube_rnd [3];
    logic signed [69:0]   u_sum [3];
    logic signed [59:0]   u_val [3];
    logic [IDX_W-1:0]     idx [3], idx_p1 [3];
    logic [32:0]          frac_rnd [3];
    logic [7:0]           ch_val [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            s1_pa_next[r]  = 52'(COEF_A[r]) * 52'(oklab.green_red);
            s1_pb_next[r]  = 52'(COEF_B[r]) * 52'(oklab.blue_yellow);
            s2_div_next[r] = DIV1_W'(53'(s1_pa_reg[r]) + 53'(s1_pb_reg[r]) + 53'(BIAS1));
            // L * 1e10 / 1e10 * 1024 is exact, only the a/b part needs the divide
            lp_sum[r]      = (30'(s5_l_reg) <<< 10) + 30'(q1[r]) - 30'(DIV_OFFSET);
            s6_lp_next[r]  = lp_sum[r][27:0];
            s7_sq_next[r]  = 53'(56'(s6_lp_reg[r]) * 56'(s6_lp_reg[r]));
            sq_rnd[r]      = 54'(s7_sq_reg[r]) + 54'(ROUND24);
            s8_cube_next[r] = 58'(signed'({1'b0, sq_rnd[r][52:24]})) * 58'(s7_lp_reg[r]);
            cube_rnd[r]    = s8_cube_reg[r] + 58'(ROUND24);
            s9_x_next[r]   = cube_rnd[r][55:24];
        end
        for (int o = 0; o < 3; o++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s10_ph_next[o][k] = 53'(COEF_M[o][k]) * 53'(signed'(s9_x_reg[k][31:16]));
                s10_pl_next[o][k] = 54'(COEF_M[o][k]) * 54'(signed'({1'b0, s9_x_reg[k][15:0]}));
            end
            s11_hs_next[o] = 55'(s10_ph_reg[o][0]) + 55'(s10_ph_reg[o][1])
                           + 55'(s10_ph_reg[o][2]);
            s11_ls_next[o] = 56'(s10_pl_reg[o][0]) + 56'(s10_pl_reg[o][1])
                           + 56'(s10_pl_reg[o][2]);
            s12_s_next[o]  = (70'(s11_hs_reg[o]) <<< 16) + 70'(s11_ls_reg[o]);
            u_sum[o]       = s12_s_reg[o] + 70'(HALF_DEC);
            u_val[o]       = u_sum[o][69:10];
            s13_zero_next[o] = u_val[o] < 60'(DIV_D);
            s13_full_next[o] = u_val[o] >= 60'(FULL_LIMIT);
            s13_div_next[o]  = u_val[o][DIV2_W-1:0];
            s17_i_next[o]  = I_W'(q2[o][23:0]) * I_W'(ENCODE_STEPS);
            idx[o]         = s17_i_reg[o][I_W-1:24];
            idx_p1[o]      = idx[o] + IDX_W'(1);
            s18_y0_next[o] = enc_rom[idx[o]];
            s18_dy_next[o] = enc_rom[idx_p1[o]] - enc_rom[idx[o]];
            s18_r_next[o]  = s17_i_reg[o][23:0];
            s19_prod_next[o] = 32'(s18_dy_reg[o]) * 32'(s18_r_reg[o]);
            frac_rnd[o]    = 33'(s19_prod_reg[o]) + 33'(ROUND24);
            if (s19_zero_reg[o])
                ch_val[o] = 8'd0;
            else if (s19_full_reg[o])
                ch_val[o] = 8'd255;
            else
                ch_val[o] = s19_y0_reg[o] + frac_rnd[o][31:24];
        end
        out_next.red   = ch_val[0];
        out_next.green = ch_val[1];
        out_next.blue  = ch_val[2];
    end

    for (genvar gr = 0; gr < 3; gr++)
    begin : g_div
        o2s_cdiv #(.IN_W(DIV1_W)) u_div_first (
            .clk      (clk),
            .en       (en[5:3]),
            .dividend (s2_div_reg[gr]),
            .quotient (q1[gr])
        );
        o2s_cdiv #(.IN_W(DIV2_W)) u_div_second (
            .clk      (clk),
            .en       (en[16:14]),
            .dividend (s13_div_reg[gr]),
            .quotient (q2[gr])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_pa_reg <= s1_pa_next;
            s1_pb_reg <= s1_pb_next;
            s1_l_reg  <= oklab.lightness;
        end
        if (en[2])
        begin
            s2_div_reg <= s2_div_next;
            s2_l_reg   <= s1_l_reg;
        end
        if (en[3])
            s3_l_reg <= s2_l_reg;
        if (en[4])
            s4_l_reg <= s3_l_reg;
        if (en[5])
            s5_l_reg <= s4_l_reg;
        if (en[6])
            s6_lp_reg <= s6_lp_next;
        if (en[7])
        begin
            s7_sq_reg <= s7_sq_next;
            s7_lp_reg <= s6_lp_reg;
        end
        if (en[8])
            s8_cube_reg <= s8_cube_next;
        if (en[9])
            s9_x_reg <= s9_x_next;
        if (en[10])
        begin
            s10_ph_reg <= s10_ph_next;
            s10_pl_reg <= s10_pl_next;
        end
        if (en[11])
        begin
            s11_hs_reg <= s11_hs_next;
            s11_ls_reg <= s11_ls_next;
        end
        if (en[12])
            s12_s_reg <= s12_s_next;
        if (en[13])
        begin
            s13_div_reg  <= s13_div_next;
            s13_zero_reg <= s13_zero_next;
            s13_full_reg <= s13_full_next;
        end
        if (en[14])
        begin
            s14_zero_reg <= s13_zero_reg;
            s14_full_reg <= s13_full_reg;
        end
        if (en[15])
        begin
            s15_zero_reg <= s14_zero_reg;
            s15_full_reg <= s14_full_reg;
        end
        if (en[16])
        begin
            s16_zero_reg <= s15_zero_reg;
            s16_full_reg <= s15_full_reg;
        end
        if (en[17])
        begin
            s17_i_reg    <= s17_i_next;
            s17_zero_reg <= s16_zero_reg;
            s17_full_reg <= s16_full_reg;
        end
        if (en[18])
        begin
            s18_y0_reg   <= s18_y0_next;
            s18_dy_reg   <= s18_dy_next;
            s18_r_reg    <= s18_r_next;
            s18_zero_reg <= s17_zero_reg;
            s18_full_reg <= s17_full_reg;
        end
        if (en[19])
        begin
            s19_prod_reg <= s19_prod_next;
            s19_y0_reg   <= s18_y0_reg;
            s19_zero_reg <= s18_zero_reg;
            s19_full_reg <= s18_full_reg;
        end
        if (en[20])
            out_reg <= out_next;
    end

    assign srgb = out_reg;

endmodule

[sv/o2s_cdiv.sv]
// Three-stage floor divider of an unsigned value by the constant DIV_D:
// reciprocal multiply, remainder, then up to two corrections. Uses o2s_pkg.
module o2s_cdiv #(
    parameter int IN_W = 51
) (
    input  logic              clk,
    input  logic [2:0]        en,
    input  logic [IN_W-1:0]   dividend,
    output logic [IN_W-24:0]  quotient
);
    import o2s_pkg::*;

    localparam int Q_W   = IN_W - 23;
    localparam int LOW_W = IN_W - 32;
    localparam int P_W   = 32 + Q_W;
    localparam int REM_W = 26;
    localparam logic [63:0] RECIP = (64'd1 << IN_W) / 64'(DIV_D);

    logic [P_W-1:0]   p1_prod_reg, p1_prod_next;
    logic [IN_W-1:0]  p1_num_reg;
    logic [Q_W-1:0]   p2_q_reg, p2_q_next;
    logic [REM_W-1:0] p2_rem_reg, p2_rem_next;
    logic [Q_W-1:0]   p3_q_reg, p3_q_next;
    logic [IN_W-1:0]  diff;

    always_comb
    begin
        p1_prod_next = P_W'(dividend[IN_W-1:LOW_W]) * P_W'(RECIP[Q_W-1:0]);
        p2_q_next    = p1_prod_reg[P_W-1:32];
        diff         = p1_num_reg - IN_W'(p2_q_next) * IN_W'(DIV_D);
        p2_rem_next  = diff[REM_W-1:0];
        // estimate is short by at most two
        if (p2_rem_reg >= REM_W'(2 * DIV_D))
            p3_q_next = p2_q_reg + Q_W'(2);
        else if (p2_rem_reg >= REM_W'(DIV_D))
            p3_q_next = p2_q_reg + Q_W'(1);
        else
            p3_q_next = p2_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1_prod_reg <= p1_prod_next;
            p1_num_reg  <= dividend;
        end
        if (en[1])
        begin
            p2_q_reg   <= p2_q_next;
            p2_rem_reg <= p2_rem_next;
        end
        if (en[2])
            p3_q_reg <= p3_q_next;
    end

    assign quotient = p3_q_reg;

endmodule

[sv/o2s_checker.sv]
// Port-level checker for oklab_to_srgb8_pixel, bound to the top level.
// Uses o2s_pkg and the macros in oklab_to_srgb8_pixel_defines.svh.
`include "oklab_to_srgb8_pixel_defines.svh"

module o2s_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  oklab_valid,
    input logic                  oklab_stall,
    input o2s_pkg::oklab_pixel_t oklab,
    input logic                  srgb_valid,
    input logic                  srgb_stall,
    input o2s_pkg::srgb_pixel_t  srgb
);
    import o2s_pkg::*;

    // a stalled output transaction holds
    `O2S_ASSERT_NEXT(a_out_hold, clk, rst_n, srgb_valid && srgb_stall, srgb_valid && $stable(srgb))
    // a stalled input transaction holds
    `O2S_ASSERT_NEXT(a_in_hold, clk, rst_n, oklab_valid && oklab_stall, $stable({oklab_valid, oklab}))
    // an unstalled receiver never backs up the input
    `O2S_ASSERT_IMPL(a_no_backpressure, clk, rst_n, !srgb_stall, !oklab_stall)
    // input stalls only with a valid output waiting on the receiver
    `O2S_ASSERT_IMPL(a_stall_cause, clk, rst_n, oklab_stall, srgb_valid && srgb_stall)

endmodule

bind oklab_to_srgb8_pixel o2s_checker u_o2s_checker (.*);
